// ===== hw/rtl/tdcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdcf_pkg
// Shared types, sizes and helpers for the truncated digest collision finder.
// ----------------------------------------------------------------------------
package tdcf_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;

   // Field widths
   localparam int DIGEST_W    = 32;
   localparam int TRUNC_W     = 6;
   localparam int MATCH_W     = 16;
   localparam int RUN_W       = 32;

   // Number of digest bits, the saturation point of the truncation setting
   localparam logic [TRUNC_W-1:0] DIGEST_BITS = TRUNC_W'(DIGEST_W);

   // Search command from the control path to the table engine
   typedef struct packed {
      logic                start;
      logic [DIGEST_W-1:0] kept;
   } tdcf_cmd_type;

   // Search status from the table engine, valid while done is high
   typedef struct packed {
      logic              done;
      logic              hit;
      logic [ADDR_W-1:0] match_idx;
      logic              full;
   } tdcf_sts_type;

   // Build the left-aligned keep mask, saturating the bit count at the digest width
   function automatic logic [DIGEST_W-1:0] keep_mask(input logic [TRUNC_W-1:0] bits);
      logic [TRUNC_W-1:0] sat;
      sat = (bits > DIGEST_BITS) ? DIGEST_BITS : bits;
      if (sat == '0) begin
         return '0;
      end
      return {DIGEST_W{1'b1}} << (DIGEST_BITS - sat);
   endfunction

endpackage

// ===== hw/rtl/tdcf_channels.sv =====
// ----------------------------------------------------------------------------
// tdcf channels
// Valid/ready channel interfaces for requests, responses and the CSR write.
// ----------------------------------------------------------------------------
interface tdcf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_prefix;

   modport source (output valid, output digest_prefix, input ready);
   modport sink   (input valid, input digest_prefix, output ready);
endinterface

interface tdcf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] kept_value;
   logic        collision;
   logic [15:0] match_index;
   logic [31:0] run_number;
   logic        table_full;
   logic        stopped;

   modport source (output valid, output kept_value, output collision, output match_index,
                   output run_number, output table_full, output stopped, input ready);
   modport sink   (input valid, input kept_value, input collision, input match_index,
                   input run_number, input table_full, input stopped, output ready);
endinterface

interface tdcf_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] truncation_bits;

   modport source (output valid, output truncation_bits, input ready);
   modport sink   (input valid, input truncation_bits, output ready);
endinterface

// ===== hw/rtl/tdcf_table_scan.sv =====
// ----------------------------------------------------------------------------
// tdcf_table_scan
// Value table and linear search engine: scans stored entries one read per
// cycle, stops at the first match, then appends the new value.
// ----------------------------------------------------------------------------
module tdcf_table_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  tdcf_pkg::tdcf_cmd_type cmd,
   output tdcf_pkg::tdcf_sts_type sts
);
   import tdcf_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } scan_state_type;

   scan_state_type      state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  ptr_ff, ptr_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [ADDR_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [DIGEST_W-1:0] kept_ff, kept_in;
   tdcf_sts_type        sts_ff, sts_in;

   logic [DIGEST_W-1:0] mem [TABLE_DEPTH];
   logic [DIGEST_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [DIGEST_W-1:0] wr_data;
   logic [COUNT_W-1:0]  last_idx;

   assign last_idx = count_ff - COUNT_W'(1);
   assign rd_addr  = ptr_ff[ADDR_W-1:0];
   assign wr_addr  = count_ff[ADDR_W-1:0];

   // Sequence the search: issue one read per cycle, compare the returned entry
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      kept_in    = kept_ff;
      sts_in     = '0;
      wr_en      = 1'b0;
      wr_data    = kept_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               kept_in = cmd.kept;
               if (count_ff >= COUNT_W'(TABLE_DEPTH)) begin
                  sts_in.done = 1'b1;
                  sts_in.full = 1'b1;
               end else if (count_ff == '0) begin
                  wr_en       = 1'b1;
                  wr_data     = cmd.kept;
                  count_in    = count_ff + COUNT_W'(1);
                  sts_in.done = 1'b1;
               end else begin
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue the next read while entries remain
            if (ptr_ff < count_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = ptr_ff[ADDR_W-1:0];
               ptr_in     = ptr_ff + COUNT_W'(1);
            end
            // Compare the entry read last cycle; finish on hit or last entry
            if (chk_vld_ff) begin
               if (rd_data_ff == kept_ff) begin
                  sts_in.done      = 1'b1;
                  sts_in.hit       = 1'b1;
                  sts_in.match_idx = chk_idx_ff;
                  wr_en            = 1'b1;
                  count_in         = count_ff + COUNT_W'(1);
                  chk_vld_in       = 1'b0;
                  state_in         = S_IDLE;
               end else if ({1'b0, chk_idx_ff} == last_idx) begin
                  sts_in.done = 1'b1;
                  wr_en       = 1'b1;
                  count_in    = count_ff + COUNT_W'(1);
                  chk_vld_in  = 1'b0;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, counters and the status pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         ptr_ff     <= '0;
         chk_vld_ff <= 1'b0;
         sts_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ptr_ff     <= ptr_in;
         chk_vld_ff <= chk_vld_in;
         sts_ff     <= sts_in;
      end
      chk_idx_ff <= chk_idx_in;
      kept_ff    <= kept_in;
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign sts = sts_ff;

endmodule

// ===== hw/rtl/truncated_digest_collision_finder.sv =====
// ----------------------------------------------------------------------------
// truncated_digest_collision_finder
// Birthday collision search over a linear table of truncated digest prefixes.
//
//   channel  | dir | payload                                   | transfer when
//   ---------+-----+-------------------------------------------+---------------
//   req_bus  | in  | digest_prefix                             | valid & ready
//   rsp_bus  | out | kept_value collision match_index          | valid & ready
//            |     | run_number table_full stopped             |
//   csr_bus  | in  | truncation_bits                           | valid & ready
//
// A searched item scans the stored entries from index 0 until a match or the last
// entry: the memory delivers one entry per cycle. The first stored item and a
// full-table item need no scan, and a stopped item does not reach the table.
// A busy output register adds its wait. One item is in work at a time; the next
// request is taken while the previous response waits in the output register.
// Reset clears entry count, run counter and found flag, not the table. CSR is always ready.
// ----------------------------------------------------------------------------
module truncated_digest_collision_finder (
   input  logic       clock,
   input  logic       reset,
   tdcf_req_if.sink   req_bus,
   tdcf_rsp_if.source rsp_bus,
   tdcf_csr_if.sink   csr_bus
);
   import tdcf_pkg::*;

   typedef enum logic [1:0] {
      T_IDLE,
      T_SCAN,
      T_DELIVER
   } ctl_state_type;

   ctl_state_type       state_ff, state_in;
   logic [TRUNC_W-1:0]  trunc_ff, trunc_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic                found_ff, found_in;

   // Pending result of the item in work
   logic [DIGEST_W-1:0] pend_kept_ff, pend_kept_in;
   logic [RUN_W-1:0]    pend_run_ff, pend_run_in;
   logic                pend_hit_ff, pend_hit_in;
   logic [MATCH_W-1:0]  pend_idx_ff, pend_idx_in;
   logic                pend_full_ff, pend_full_in;
   logic                pend_stop_ff, pend_stop_in;

   // Output register
   logic                rsp_vld_ff, rsp_vld_in;
   logic [DIGEST_W-1:0] rsp_kept_ff, rsp_kept_in;
   logic [RUN_W-1:0]    rsp_run_ff, rsp_run_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [MATCH_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic                rsp_full_ff, rsp_full_in;
   logic                rsp_stop_ff, rsp_stop_in;

   logic                req_xfer;
   logic [DIGEST_W-1:0] kept;
   tdcf_cmd_type        cmd;
   tdcf_sts_type        sts;

   assign req_bus.ready = (state_ff == T_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_xfer      = req_bus.valid & req_bus.ready;
   assign kept          = req_bus.digest_prefix & keep_mask(trunc_ff);

   tdcf_table_scan u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   // Control: take requests, start searches, collect and deliver results
   always_comb begin
      state_in     = state_ff;
      trunc_in     = trunc_ff;
      run_in       = run_ff;
      found_in     = found_ff;
      pend_kept_in = pend_kept_ff;
      pend_run_in  = pend_run_ff;
      pend_hit_in  = pend_hit_ff;
      pend_idx_in  = pend_idx_ff;
      pend_full_in = pend_full_ff;
      pend_stop_in = pend_stop_ff;
      rsp_vld_in   = rsp_vld_ff & ~rsp_bus.ready;
      rsp_kept_in  = rsp_kept_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_stop_in  = rsp_stop_ff;
      cmd.start    = 1'b0;
      cmd.kept     = kept;

      if (csr_bus.valid) begin
         trunc_in = csr_bus.truncation_bits;
      end

      case (state_ff)
         T_IDLE: begin
            if (req_xfer) begin
               pend_kept_in = kept;
               pend_run_in  = run_ff;
               run_in       = run_ff + RUN_W'(1);
               pend_hit_in  = 1'b0;
               pend_idx_in  = '0;
               pend_full_in = 1'b0;
               if (found_ff) begin
                  pend_stop_in = 1'b1;
                  state_in     = T_DELIVER;
               end else begin
                  pend_stop_in = 1'b0;
                  cmd.start    = 1'b1;
                  state_in     = T_SCAN;
               end
            end
         end
         T_SCAN: begin
            if (sts.done) begin
               pend_hit_in  = sts.hit;
               pend_idx_in  = sts.hit ? MATCH_W'(sts.match_idx) : '0;
               pend_full_in = sts.full;
               found_in     = found_ff | sts.hit;
               state_in     = T_DELIVER;
            end
         end
         T_DELIVER: begin
            // Load the output register once it is empty or draining
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in  = 1'b1;
               rsp_kept_in = pend_kept_ff;
               rsp_run_in  = pend_run_ff;
               rsp_hit_in  = pend_hit_ff;
               rsp_idx_in  = pend_idx_ff;
               rsp_full_in = pend_full_ff;
               rsp_stop_in = pend_stop_ff;
               state_in    = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Hold control state, counters and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= T_IDLE;
         trunc_ff   <= DIGEST_BITS;
         run_ff     <= '0;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         trunc_ff   <= trunc_in;
         run_ff     <= run_in;
         found_ff   <= found_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      pend_kept_ff <= pend_kept_in;
      pend_run_ff  <= pend_run_in;
      pend_hit_ff  <= pend_hit_in;
      pend_idx_ff  <= pend_idx_in;
      pend_full_ff <= pend_full_in;
      pend_stop_ff <= pend_stop_in;
      rsp_kept_ff  <= rsp_kept_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_stop_ff  <= rsp_stop_in;
   end

   // Drive the response channel from the output register
   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.kept_value  = rsp_kept_ff;
   assign rsp_bus.collision   = rsp_hit_ff;
   assign rsp_bus.match_index = rsp_idx_ff;
   assign rsp_bus.run_number  = rsp_run_ff;
   assign rsp_bus.table_full  = rsp_full_ff;
   assign rsp_bus.stopped     = rsp_stop_ff;

endmodule

// ===== bench/tdcf_collision_checker.sv =====
// ----------------------------------------------------------------------------
// tdcf_collision_checker
// Watches the request, response and CSR channels of the collision finder.
// It mirrors the key table, run counter and found flag, predicts one report
// per accepted digest and compares every response transfer against the
// oldest outstanding report, field by field.
// ----------------------------------------------------------------------------
module tdcf_collision_checker (
   input  logic clock,
   input  logic reset,
   tdcf_req_if  req_bus,
   tdcf_rsp_if  rsp_bus,
   tdcf_csr_if  csr_bus,
   output int   failures,
   output int   backlog
);
   import tdcf_pkg::*;

   typedef struct packed {
      logic [DIGEST_W-1:0] kept_value;
      logic                collision;
      logic [MATCH_W-1:0]  match_index;
      logic [RUN_W-1:0]    run_number;
      logic                table_full;
      logic                stopped;
   } collision_report_type;

   // Mirror of the block state
   logic [TRUNC_W-1:0]   trunc_setting;
   logic [DIGEST_W-1:0]  stored_keys[$];
   logic [RUN_W-1:0]     run_count;
   logic                 found;
   collision_report_type expected_reports[$];
   int                   fail_total = 0;

   // Compute the report for one digest and advance the mirrored state
   function automatic collision_report_type predict_report(
      input logic [DIGEST_W-1:0] digest);
      collision_report_type rep;
      int                   sat;
      int                   idx;
      rep = '0;
      sat = (trunc_setting > DIGEST_W) ? DIGEST_W : int'(trunc_setting);
      rep.kept_value = digest & ~({DIGEST_W{1'b1}} >> sat);
      rep.run_number = run_count;
      run_count = run_count + 1'b1;
      if (found) begin
         rep.stopped = 1'b1;
      end else if (stored_keys.size() >= TABLE_DEPTH) begin
         rep.table_full = 1'b1;
      end else begin
         // first earlier entry that equals the kept value wins
         for (idx = 0; idx < stored_keys.size(); idx++) begin
            if (!rep.collision && stored_keys[idx] == rep.kept_value) begin
               rep.collision   = 1'b1;
               rep.match_index = MATCH_W'(idx);
            end
         end
         stored_keys.push_back(rep.kept_value);
         found = rep.collision;
      end
      return rep;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_total++;
      end
   endtask

   // Track transfers on all three channels
   always @(posedge clock) begin : monitor
      collision_report_type want;
      if (reset) begin
         trunc_setting = DIGEST_BITS;
         stored_keys.delete();
         expected_reports.delete();
         run_count = '0;
         found     = 1'b0;
      end else begin
         // queue the prediction for an accepted digest
         if (req_bus.valid && req_bus.ready) begin
            expected_reports.push_back(predict_report(req_bus.digest_prefix));
         end
         // compare a response transfer with the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_reports.size() == 0) begin
               $error("response transfer with no report outstanding");
               fail_total++;
            end else begin
               want = expected_reports.pop_front();
               check_field("kept_value", want.kept_value, rsp_bus.kept_value);
               check_field("collision", 32'(want.collision), 32'(rsp_bus.collision));
               check_field("match_index", 32'(want.match_index), 32'(rsp_bus.match_index));
               check_field("run_number", want.run_number, rsp_bus.run_number);
               check_field("table_full", 32'(want.table_full), 32'(rsp_bus.table_full));
               check_field("stopped", 32'(want.stopped), 32'(rsp_bus.stopped));
            end
         end
         // new setting applies to later digests only
         if (csr_bus.valid && csr_bus.ready) begin
            trunc_setting = csr_bus.truncation_bits;
         end
      end
      failures <= fail_total;
      backlog  <= expected_reports.size();
   end

endmodule

// ===== bench/tb_truncated_digest_collision_finder.sv =====
// ----------------------------------------------------------------------------
// tb_truncated_digest_collision_finder
// Stimulus and verdict for the truncated digest collision finder. Digests
// are kept collision free while the table grows under several truncation
// settings, then one zero-truncation digest forces the collision and the
// remaining digests exercise the stopped path. A side checker predicts and
// compares; this module only drives the channels and reports the outcome.
// ----------------------------------------------------------------------------
module tb_truncated_digest_collision_finder;
   import tdcf_pkg::*;

   // Longest correct stretch without a transfer is a scan of under a hundred
   // entries plus a receiver stall; allow many times that
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 16;

   logic clock;
   logic reset;

   tdcf_req_if req_bus ();
   tdcf_rsp_if rsp_bus ();
   tdcf_csr_if csr_bus ();

   int failures;
   int backlog;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles = 0;

   logic [TRUNC_W-1:0]  trunc_now;
   logic [DIGEST_W-1:0] sent_keys[$];

   truncated_digest_collision_finder uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tdcf_collision_checker checker_inst (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_bus  (csr_bus),
      .failures (failures),
      .backlog  (backlog)
   );

   always #1 clock = ~clock;

   // Stall the receiver at the current rate
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Abort when no channel transfers for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("[truncated_digest_collision_finder] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [DIGEST_W-1:0] kept_bits(input logic [DIGEST_W-1:0] digest);
      int sat;
      sat = (trunc_now > DIGEST_W) ? DIGEST_W : int'(trunc_now);
      return digest & ~({DIGEST_W{1'b1}} >> sat);
   endfunction

   // Offer one digest after a random gap; valid stays high on return
   task automatic send_digest(input logic [DIGEST_W-1:0] digest);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.digest_prefix <= digest;
      sent_keys.push_back(kept_bits(digest));
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Hold requests until every report is back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
   endtask

   task automatic write_truncation(input logic [TRUNC_W-1:0] bits);
      wait_idle();
      csr_bus.valid           <= 1'b1;
      csr_bus.truncation_bits <= bits;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      trunc_now = bits;
   endtask

   initial begin : stimulus
      int                  profile;
      logic [DIGEST_W-1:0] candidate;
      bit                  redraw;
      clock                   = 1'b0;
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.digest_prefix   = '0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.truncation_bits = '0;
      trunc_now               = DIGEST_BITS;
      send_idle_pct           = 38;
      recv_idle_pct           = 45;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Field extremes under the reset setting, all distinct
      send_digest(32'hFFFF_FFFF);
      send_digest(32'h8000_0000);
      send_digest(32'h7FFF_FFFF);
      send_digest(32'h0000_0001);
      send_digest(32'hFFFF_FFFE);
      send_digest(32'hAAAA_AAAA);
      send_digest(32'h5555_5555);
      // Settings above the digest width saturate
      write_truncation(6'd63);
      send_digest(32'h0F0F_0F0F);
      send_digest(32'hF0F0_F0F0);
      write_truncation(6'd33);
      send_digest(32'h0123_4567);
      // Narrower settings leave stored keys untouched
      write_truncation(6'd16);
      send_digest(32'h5A5A_1234);
      send_digest(32'hC3C3_FFFF);
      write_truncation(6'd31);
      send_digest(32'h0000_0003);

      // Random collision-free digests over three idling profiles
      for (profile = 0; profile < 3; profile++) begin
         send_idle_pct = (profile == 0) ? 38 : (profile == 1) ? 45 : 0;
         recv_idle_pct = (profile == 0) ? 45 : (profile == 1) ? 38 : 0;
         repeat (2) begin
            if ($urandom_range(3) == 0) begin
               write_truncation(TRUNC_W'($urandom_range(63, 33)));
            end else begin
               write_truncation(TRUNC_W'($urandom_range(32, 12)));
            end
            repeat (10) begin
               // redraw until the kept key is new to the table
               redraw = 1'b1;
               while (redraw) begin
                  candidate = $urandom();
                  redraw    = 1'b0;
                  foreach (sent_keys[i]) begin
                     if (sent_keys[i] == kept_bits(candidate)) redraw = 1'b1;
                  end
               end
               send_digest(candidate);
            end
         end
      end

      // Store an all-zero key, then zero truncation collides with it
      write_truncation(6'd32);
      send_digest(32'h0000_0000);
      write_truncation(6'd0);
      send_digest($urandom());

      // Everything after the collision reports stopped
      repeat (5) begin
         write_truncation(TRUNC_W'($urandom_range(63)));
         repeat (5) send_digest($urandom());
      end

      // Drain outstanding reports
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && backlog == 0) begin
         $display("[truncated_digest_collision_finder] OK");
      end else begin
         $display("[truncated_digest_collision_finder] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/tdcf_pkg.sv
hw/rtl/tdcf_channels.sv
hw/rtl/tdcf_table_scan.sv
hw/rtl/truncated_digest_collision_finder.sv
bench/tdcf_collision_checker.sv
bench/tb_truncated_digest_collision_finder.sv
